// ===== rtl/priority_queue_fifo_ties_top_defines.svh =====
`ifndef PRIORITY_QUEUE_FIFO_TIES_TOP_DEFINES_SVH
`define PRIORITY_QUEUE_FIFO_TIES_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define PQFT_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pqft check failed");

// Next-cycle implication, checked on every rising edge outside reset
`define PQFT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pqft check failed");

`endif

// ===== rtl/pqft_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pqft_pkg;

  // Queue geometry
  localparam int Capacity = 16;
  localparam int IdxW     = $clog2(Capacity);
  localparam int CntW     = 5;

  // Field widths
  localparam int ValueW = 32;
  localparam int PrioW  = 16;
  localparam int StatW  = 2;

  // Request kinds
  localparam logic ActEnqueue = 1'b0;
  localparam logic ActDequeue = 1'b1;

  // Result status codes
  typedef enum logic [StatW-1:0] {
    StEnqueued = 2'd0,
    StDequeued = 2'd1,
    StEmpty    = 2'd2,
    StFull     = 2'd3
  } status_e;

endpackage

`default_nettype wire

// ===== rtl/priority_queue_fifo_ties_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "priority_queue_fifo_ties_top_defines.svh"

// Bounded priority queue of 16 entries kept in arrival order. An enqueue request
// appends at the tail; its result, like that of a dequeue on an empty queue, goes
// through the emit state into the output register before the next request is taken.
// A dequeue request is handled by one shared signed comparator that walks the
// stored entries one per cycle, keeping the first strict maximum so that equal
// priorities leave oldest first, and then closes the gap one entry per cycle
// through the same read port before the result goes through the emit state.
// The input stalls until the result sits in the output register, and a stalled
// output register holds the block in the emit state until it is free. Each request
// yields exactly one result with status, occupancy and an empty flag.
module priority_queue_fifo_ties_top (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic                                   action_i,
  input  wire logic signed [pqft_pkg::ValueW-1:0]     item_value_i,
  input  wire logic signed [pqft_pkg::PrioW-1:0]      item_priority_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic signed [pqft_pkg::ValueW-1:0]          out_value_o,
  output logic [pqft_pkg::StatW-1:0]                  status_o,
  output logic [pqft_pkg::CntW-1:0]                   occupancy_o,
  output logic                                        is_empty_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_EMIT
  } state_e;

  localparam logic [pqft_pkg::CntW-1:0] CapCnt = pqft_pkg::CntW'(pqft_pkg::Capacity);

  // Entry storage, payload only
  logic signed [pqft_pkg::ValueW-1:0] val_mem [pqft_pkg::Capacity];
  logic signed [pqft_pkg::PrioW-1:0]  pri_mem [pqft_pkg::Capacity];

  state_e                              state_q;
  logic [pqft_pkg::CntW-1:0]           count_q;
  logic [pqft_pkg::CntW-1:0]           idx_q;
  logic [pqft_pkg::IdxW-1:0]           best_idx_q;
  logic signed [pqft_pkg::PrioW-1:0]   best_pri_q;
  logic signed [pqft_pkg::ValueW-1:0]  best_val_q;
  pqft_pkg::status_e                   res_status_q;
  logic signed [pqft_pkg::ValueW-1:0]  res_value_q;
  logic                                out_valid_q;
  logic signed [pqft_pkg::ValueW-1:0]  out_value_q;
  pqft_pkg::status_e                   out_status_q;
  logic [pqft_pkg::CntW-1:0]           out_count_q;

  logic                                in_acc;
  logic                                out_free;
  logic [pqft_pkg::IdxW-1:0]           rd_idx;
  logic signed [pqft_pkg::ValueW-1:0]  rd_val;
  logic signed [pqft_pkg::PrioW-1:0]   rd_pri;
  logic                                scan_more;
  logic                                shift_more;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Select the single read address: head at idle, scan cursor, or entry behind the gap
  always_comb begin
    case (state_q)
      S_IDLE:  rd_idx = '0;
      S_SHIFT: rd_idx = idx_q[pqft_pkg::IdxW-1:0] + 1'b1;
      default: rd_idx = idx_q[pqft_pkg::IdxW-1:0];
    endcase
  end

  assign rd_val     = val_mem[rd_idx];
  assign rd_pri     = pri_mem[rd_idx];
  assign scan_more  = (idx_q < count_q);
  assign shift_more = ((idx_q + 1'b1) < count_q);

  // Write entries: append on enqueue, close up on compaction
  always_ff @(posedge clk_i) begin
    if (in_acc && action_i == pqft_pkg::ActEnqueue && count_q < CapCnt) begin
      val_mem[count_q[pqft_pkg::IdxW-1:0]] <= item_value_i;
      pri_mem[count_q[pqft_pkg::IdxW-1:0]] <= item_priority_i;
    end else if (state_q == S_SHIFT && shift_more) begin
      val_mem[idx_q[pqft_pkg::IdxW-1:0]] <= rd_val;
      pri_mem[idx_q[pqft_pkg::IdxW-1:0]] <= rd_pri;
    end
  end

  // Sequence each request and hold the registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
      best_idx_q   <= '0;
      best_pri_q   <= '0;
      best_val_q   <= '0;
      res_status_q <= pqft_pkg::StEnqueued;
      res_value_q  <= '0;
      out_value_q  <= '0;
      out_status_q <= pqft_pkg::StEnqueued;
      out_count_q  <= '0;
    end else begin
      // drop the result once taken
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            res_value_q <= '0;
            if (action_i == pqft_pkg::ActEnqueue) begin
              if (count_q < CapCnt) begin
                count_q      <= count_q + 1'b1;
                res_status_q <= pqft_pkg::StEnqueued;
              end else begin
                res_status_q <= pqft_pkg::StFull;
              end
              state_q <= S_EMIT;
            end else if (count_q == '0) begin
              res_status_q <= pqft_pkg::StEmpty;
              state_q      <= S_EMIT;
            end else begin
              // seed the search with the oldest entry
              best_idx_q <= '0;
              best_pri_q <= rd_pri;
              best_val_q <= rd_val;
              idx_q      <= pqft_pkg::CntW'(1);
              state_q    <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_more) begin
            // only a strictly larger priority displaces the current best
            if (rd_pri > best_pri_q) begin
              best_idx_q <= idx_q[pqft_pkg::IdxW-1:0];
              best_pri_q <= rd_pri;
              best_val_q <= rd_val;
            end
            idx_q <= idx_q + 1'b1;
          end else begin
            idx_q   <= {1'b0, best_idx_q};
            state_q <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (shift_more) begin
            idx_q <= idx_q + 1'b1;
          end else begin
            count_q      <= count_q - 1'b1;
            res_status_q <= pqft_pkg::StDequeued;
            res_value_q  <= best_val_q;
            state_q      <= S_EMIT;
          end
        end
        S_EMIT: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_value_q  <= res_value_q;
            out_status_q <= res_status_q;
            out_count_q  <= count_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign status_o    = out_status_q;
  assign occupancy_o = out_count_q;
  assign is_empty_o  = (out_count_q == '0);

  `PQFT_ASSERT(a_count_bound, 1'b1, count_q <= CapCnt)
  `PQFT_ASSERT(a_empty_zero, out_valid_q && out_status_q == pqft_pkg::StEmpty,
               out_count_q == '0 && out_value_q == '0)
  `PQFT_ASSERT(a_full_cap, out_valid_q && out_status_q == pqft_pkg::StFull,
               out_count_q == CapCnt)
  `PQFT_ASSERT_NEXT(a_enq_grows,
                    in_acc && action_i == pqft_pkg::ActEnqueue && count_q < CapCnt,
                    count_q == $past(count_q) + 1'b1)

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int RandomRequests = 1750;
  localparam int CycleLimit     = 500000;
  localparam int SettleCycles   = 2 * pqft_pkg::Capacity + 8;
  localparam int MaxReports     = 40;

  // One expected outcome of a request
  typedef struct {
    logic signed [pqft_pkg::ValueW-1:0] value;
    pqft_pkg::status_e                  status;
    logic [pqft_pkg::CntW-1:0]          occupancy;
    logic                               empty;
  } pq_outcome_t;

  // Shadow of the stored entries plus the outcomes still owed by the block
  class pq_scoreboard;
    logic signed [pqft_pkg::ValueW-1:0] held_values[$];
    logic signed [pqft_pkg::PrioW-1:0]  held_prios[$];
    pq_outcome_t                        owed_outcomes[$];
    int                                 error_count;

    function new();
      error_count = 0;
    endfunction

    function int pending();
      return owed_outcomes.size();
    endfunction

    // Apply one accepted request to the shadow queue and note what it yields
    function void note_request(logic act, logic signed [pqft_pkg::ValueW-1:0] value,
                               logic signed [pqft_pkg::PrioW-1:0] prio);
      pq_outcome_t res;
      int          best;
      res.value = '0;
      if (act == pqft_pkg::ActEnqueue) begin
        if (held_values.size() >= pqft_pkg::Capacity) begin
          res.status = pqft_pkg::StFull;
        end else begin
          held_values.push_back(value);
          held_prios.push_back(prio);
          res.status = pqft_pkg::StEnqueued;
        end
      end else if (held_values.size() == 0) begin
        res.status = pqft_pkg::StEmpty;
      end else begin
        // strict compare: the oldest entry wins among equal priorities
        best = 0;
        for (int i = 1; i < held_values.size(); i++) begin
          if (held_prios[i] > held_prios[best]) best = i;
        end
        res.value = held_values[best];
        held_values.delete(best);
        held_prios.delete(best);
        res.status = pqft_pkg::StDequeued;
      end
      res.occupancy = pqft_pkg::CntW'(held_values.size());
      res.empty     = (held_values.size() == 0);
      owed_outcomes.push_back(res);
    endfunction

    function void report(string field, logic [pqft_pkg::ValueW-1:0] exp_v,
                         logic [pqft_pkg::ValueW-1:0] act_v);
      error_count++;
      if (error_count <= MaxReports) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
      end
    endfunction

    // Compare one accepted result with the oldest outstanding outcome
    function void check_result(logic [pqft_pkg::ValueW-1:0] value,
                               logic [pqft_pkg::StatW-1:0] status,
                               logic [pqft_pkg::CntW-1:0] occupancy, logic empty);
      pq_outcome_t exp_res;
      if (owed_outcomes.size() == 0) begin
        report("unexpected result status", '0, pqft_pkg::ValueW'(status));
        return;
      end
      exp_res = owed_outcomes.pop_front();
      if (value !== exp_res.value) report("out_value", exp_res.value, value);
      if (status !== exp_res.status) begin
        report("status", pqft_pkg::ValueW'(exp_res.status), pqft_pkg::ValueW'(status));
      end
      if (occupancy !== exp_res.occupancy) begin
        report("occupancy", pqft_pkg::ValueW'(exp_res.occupancy),
               pqft_pkg::ValueW'(occupancy));
      end
      if (empty !== exp_res.empty) begin
        report("is_empty", pqft_pkg::ValueW'(exp_res.empty), pqft_pkg::ValueW'(empty));
      end
    endfunction
  endclass

  logic                               clk_i;
  logic                               rst_ni;
  logic                               in_valid_i;
  logic                               in_stall_o;
  logic                               action_i;
  logic signed [pqft_pkg::ValueW-1:0] item_value_i;
  logic signed [pqft_pkg::PrioW-1:0]  item_priority_i;
  logic                               out_valid_o;
  logic                               out_stall_i;
  logic signed [pqft_pkg::ValueW-1:0] out_value_o;
  logic [pqft_pkg::StatW-1:0]         status_o;
  logic [pqft_pkg::CntW-1:0]          occupancy_o;
  logic                               is_empty_o;

  pq_scoreboard sb;
  bit           steady_run = 1'b0;
  int           cycle_count = 0;

  priority_queue_fifo_ties_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .item_value_i    (item_value_i),
    .item_priority_i (item_priority_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_value_o     (out_value_o),
    .status_o        (status_o),
    .occupancy_o     (occupancy_o),
    .is_empty_o      (is_empty_o)
  );

  // 20 ns clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one request after a random gap and hold it until accepted
  task automatic push_request(input logic act,
                              input logic signed [pqft_pkg::ValueW-1:0] value,
                              input logic signed [pqft_pkg::PrioW-1:0] prio);
    int gap;
    gap = steady_run ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    action_i        <= act;
    item_value_i    <= value;
    item_priority_i <= prio;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(act, value, prio);
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic wait_for_drain();
    if (sb.pending() != 0) begin
      in_valid_i <= 1'b0;
      while (sb.pending() != 0) @(posedge clk_i);
    end
  endtask

  // Result side: stall at random before each result, then take it and check it
  initial begin : result_sink
    int hold;
    out_stall_i = 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      hold = steady_run ? 0 : $urandom_range(0, 4);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      sb.check_result(out_value_o, status_o, occupancy_o, is_empty_o);
    end
  end

  initial begin : stimulus
    int                                sent;
    int                                seg_len;
    int                                enq_pct;
    logic                              act;
    logic signed [pqft_pkg::PrioW-1:0] prio;
    sb              = new();
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    action_i        = pqft_pkg::ActEnqueue;
    item_value_i    = '0;
    item_priority_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: dequeue on empty, field extremes, ties, fill to full and overflow
    push_request(pqft_pkg::ActDequeue, pqft_pkg::ValueW'($urandom),
                 pqft_pkg::PrioW'($urandom));
    push_request(pqft_pkg::ActEnqueue, 32'sh8000_0000, 16'sh8000);
    push_request(pqft_pkg::ActEnqueue, 32'sh7fff_ffff, 16'sh7fff);
    push_request(pqft_pkg::ActEnqueue, 32'sh0000_0000, 16'sh0000);
    push_request(pqft_pkg::ActEnqueue, 32'shffff_ffff, 16'shffff);
    for (int k = 0; k < pqft_pkg::Capacity - 4; k++) begin
      push_request(pqft_pkg::ActEnqueue, pqft_pkg::ValueW'(32'h1000 + k),
                   (k % 4 == 0) ? 16'sh7fff : pqft_pkg::PrioW'(k % 2));
    end
    push_request(pqft_pkg::ActEnqueue, 32'sh5a5a_a5a5, 16'sh7fff);
    for (int k = 0; k < 6; k++) begin
      push_request(pqft_pkg::ActDequeue, pqft_pkg::ValueW'($urandom),
                   pqft_pkg::PrioW'($urandom));
    end
    wait_for_drain();

    // Random: segments biased towards filling, draining or balanced traffic
    sent = 0;
    while (sent < RandomRequests) begin
      seg_len = $urandom_range(20, 80);
      case ($urandom_range(0, 2))
        0:       enq_pct = 20;
        1:       enq_pct = 50;
        default: enq_pct = 80;
      endcase
      steady_run = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < seg_len; n++) begin
        act = ($urandom_range(0, 99) < enq_pct) ? pqft_pkg::ActEnqueue
                                                 : pqft_pkg::ActDequeue;
        // narrow priorities force plenty of ties
        case ($urandom_range(0, 3))
          0:       prio = pqft_pkg::PrioW'($urandom_range(0, 3));
          1:       prio = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
          default: prio = pqft_pkg::PrioW'($urandom);
        endcase
        push_request(act, pqft_pkg::ValueW'($urandom), prio);
      end
      sent += seg_len;
      if ($urandom_range(0, 3) == 0) wait_for_drain();
    end

    // Drain and let any stray result show up
    wait_for_drain();
    steady_run = 1'b0;
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
